>>> hw/rtl/grff_pkg.sv
// Package: shared types and constants for the grid rectangle first-fit unit.
package grff_pkg;
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam logic [7:0] FREE_MARK = 8'h20;
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;
    localparam logic [1:0] OP_MARK  = 2'd3;
    localparam int REG_COLS = 0;
    localparam int REG_ROWS = 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_PROBE  = 8'b0000_0100,
        S_WAIT   = 8'b0000_1000,
        S_EVAL   = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_COUNT  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;
endpackage

>>> hw/rtl/grid_rectangle_first_fit_unit.sv
// Top level: grid rectangle first-fit allocator over one cell memory.
//
// Requests enter on i_valid/o_ready with opcode, position, size and mark;
// one result per request leaves on o_valid/i_ready (ok, found position and
// the count of free cells in the used grid after the request).
// All cell marks live in one synchronous memory of MAX_ROWS*MAX_COLS bytes
// with one read and one write port; a probed cell is read through S_PROBE,
// S_WAIT and S_EVAL. Steps from accept to o_valid, N = rows*columns in use:
//   clear: write pass, then recount pass.
//   check: probe each cell, stopping at the first occupied one, then recount.
//   mark: write each cell, then recount. find: each candidate is probed
//   cell by cell, stopping at the first occupied cell, then N cells are recounted.
//   rejected size or position: recount only.
// Every request ends with the recount pass; one request is worked on at a
// time, and the next is taken only after the result has left.
// After reset the memory is swept to 0x20, one cell a cycle, while o_ready
// stays low; configuration writes are taken throughout. Writing grid size
// triggers a recount of the used grid before the next request. If the
// receiver stalls, the result is held in the output register and no new
// request is taken until it leaves.
module grid_rectangle_first_fit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_row,
    input  logic [3:0]  i_col,
    input  logic [4:0]  i_rect_width,
    input  logic [4:0]  i_rect_height,
    input  logic [7:0]  i_mark,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [3:0]  o_found_row,
    output logic [3:0]  o_found_col,
    output logic [8:0]  o_free_cells
);
    import grff_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0] MAXR5 = (MAX_ROWS > 16) ? 5'd16 : 5'(MAX_ROWS);
    localparam logic [4:0] MAXC5 = (MAX_COLS > 16) ? 5'd16 : 5'(MAX_COLS);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;
    logic       mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0] mem_wdata;

    t_state r_state;
    logic [4:0] r_cols, r_rows;
    logic       r_init, r_recount;
    logic [AW-1:0] r_sweep;
    logic [1:0] r_op;
    logic [4:0] r_w, r_h, r_r0, r_c0, r_r, r_c;
    logic [7:0] r_mk;
    logic       r_ok, r_fail;
    logic [8:0] r_cnt;
    logic [3:0] r_frow, r_fcol;
    logic       r_ov;
    logic [8:0] r_free;
    logic       r_is_req;

    function automatic logic [4:0] clamp(input logic [4:0] v, input logic [4:0] m);
        logic [4:0] t;
        t = (v == 5'd0) ? 5'd1 : v;
        return (t > m) ? m : t;
    endfunction

    function automatic logic [AW-1:0] addr(input logic [4:0] r, input logic [4:0] c);
        logic [AW+5:0] a;
        a = (AW+6)'(r) * (AW+6)'(MAX_COLS) + (AW+6)'(c);
        return a[AW-1:0];
    endfunction

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {27'd0, r_cols};
            default: prdata = {27'd0, r_rows};
        endcase
    end
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    assign o_ready = (r_state == S_IDLE) && !r_init && !r_recount && !r_ov;
    assign o_valid = r_ov;
    assign o_free_cells = r_free;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    logic [5:0] r_end_r, r_end_c;
    assign r_end_r = 6'(r_r0) + 6'(r_h);
    assign r_end_c = 6'(r_c0) + 6'(r_w);

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = addr(r_r, r_c);
        mem_wdata = r_mk;
        mem_raddr = addr(r_r, r_c);
        if (r_init) begin
            mem_we = 1'b1;
            mem_waddr = r_sweep;
            mem_wdata = FREE_MARK;
        end else if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wdata = FREE_MARK;
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
        end
    end

    logic last_c_u, last_r_u, last_c_re, last_r_re;
    assign last_c_u  = (r_c + 5'd1 == r_cols);
    assign last_r_u  = (r_r + 5'd1 == r_rows);
    assign last_c_re = (6'(r_c) + 6'd1 == r_end_c);
    assign last_r_re = (6'(r_r) + 6'd1 == r_end_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cols    <= MAXC5;
            r_rows    <= MAXR5;
            r_init    <= 1'b1;
            r_recount <= 1'b0;
            r_sweep   <= '0;
            r_ov      <= 1'b0;
            r_fail    <= 1'b0;
            r_free    <= 9'(32'(MAXR5) * 32'(MAXC5));
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == 1'(REG_COLS)) r_cols <= clamp(pwdata[4:0], MAXC5);
                else                          r_rows <= clamp(pwdata[4:0], MAXR5);
                r_recount <= 1'b1;
            end
            if (r_ov && i_ready) r_ov <= 1'b0;
            else if (r_state == S_OUT && r_is_req) r_ov <= 1'b1;
            if (r_init) begin
                r_sweep <= r_sweep + 1'b1;
                if (r_sweep == AW'(DEPTH - 1)) r_init <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!r_init && r_recount && !cfg_wr && !r_ov) begin
                        r_recount <= 1'b0;
                        r_op <= OP_CHECK;
                        r_r <= '0; r_c <= '0; r_cnt <= '0;
                        r_state <= S_COUNT;
                    end else if (i_valid && o_ready) begin
                        r_op <= i_opcode;
                        r_w <= i_rect_width; r_h <= i_rect_height;
                        r_mk <= i_mark;
                        r_frow <= '0; r_fcol <= '0;
                        r_ok <= 1'b0;
                        r_fail <= 1'b0;
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_r <= '0; r_c <= '0;
                                r_state <= S_CLEAR;
                            end
                            OP_FIND: begin
                                if (i_rect_width != 0 && i_rect_height != 0 &&
                                    i_rect_height <= r_rows && i_rect_width <= r_cols) begin
                                    r_r0 <= r_rows - i_rect_height; r_c0 <= '0;
                                    r_r <= r_rows - i_rect_height; r_c <= '0;
                                    r_state <= S_PROBE;
                                end else begin
                                    r_r <= '0; r_c <= '0; r_cnt <= '0;
                                    r_state <= S_COUNT;
                                end
                            end
                            default: begin
                                r_r0 <= 5'(i_row); r_c0 <= 5'(i_col);
                                r_r <= 5'(i_row); r_c <= 5'(i_col);
                                if (i_rect_width != 0 && i_rect_height != 0 &&
                                    6'(i_row) + 6'(i_rect_height) <= 6'(r_rows) &&
                                    6'(i_col) + 6'(i_rect_width) <= 6'(r_cols)) begin
                                    r_state <= (i_opcode == OP_MARK) ? S_WRITE : S_PROBE;
                                end else begin
                                    r_r <= '0; r_c <= '0; r_cnt <= '0;
                                    r_state <= S_COUNT;
                                end
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (last_c_u) begin
                        r_c <= '0;
                        if (last_r_u) begin
                            r_r <= '0; r_cnt <= '0; r_ok <= 1'b1;
                            r_state <= S_COUNT;
                        end else r_r <= r_r + 5'd1;
                    end else r_c <= r_c + 5'd1;
                end
                S_PROBE: r_state <= S_WAIT;
                S_WAIT:  r_state <= S_EVAL;
                S_EVAL: begin
                    if (r_rdata != FREE_MARK) begin
                        if (r_op == OP_FIND) begin
                            if (6'(r_c0) + 6'(r_w) + 6'd1 <= 6'(r_cols)) begin
                                r_c0 <= r_c0 + 5'd1;
                                r_r <= r_r0; r_c <= r_c0 + 5'd1;
                                r_state <= S_PROBE;
                            end else if (r_r0 != 0) begin
                                r_r0 <= r_r0 - 5'd1; r_c0 <= '0;
                                r_r <= r_r0 - 5'd1; r_c <= '0;
                                r_state <= S_PROBE;
                            end else begin
                                r_r <= '0; r_c <= '0; r_cnt <= '0;
                                r_state <= S_COUNT;
                            end
                        end else begin
                            r_r <= '0; r_c <= '0; r_cnt <= '0;
                            r_state <= S_COUNT;
                        end
                    end else if (last_c_re && last_r_re) begin
                        r_ok <= 1'b1;
                        if (r_op == OP_FIND) begin
                            r_frow <= r_r0[3:0]; r_fcol <= r_c0[3:0];
                        end
                        r_r <= '0; r_c <= '0; r_cnt <= '0;
                        r_state <= S_COUNT;
                    end else begin
                        if (last_c_re) begin
                            r_c <= r_c0; r_r <= r_r + 5'd1;
                        end else r_c <= r_c + 5'd1;
                        r_state <= S_PROBE;
                    end
                end
                S_WRITE: begin
                    if (last_c_re) begin
                        r_c <= r_c0;
                        if (last_r_re) begin
                            r_ok <= 1'b1;
                            r_r <= '0; r_c <= '0; r_cnt <= '0;
                            r_state <= S_COUNT;
                        end else r_r <= r_r + 5'd1;
                    end else r_c <= r_c + 5'd1;
                end
                S_COUNT: begin
                    // read issued here; tally gated by r_fail, last cell added in S_OUT
                    r_fail <= 1'b1;
                    if (r_fail && r_rdata == FREE_MARK) r_cnt <= r_cnt + 9'd1;
                    if (last_c_u) begin
                        r_c <= '0;
                        if (last_r_u) r_state <= S_OUT;
                        else r_r <= r_r + 5'd1;
                    end else r_c <= r_c + 5'd1;
                end
                S_OUT: begin
                    r_fail <= 1'b0;
                    r_free <= r_cnt + ((r_rdata == FREE_MARK) ? 9'd1 : 9'd0);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_is_req <= 1'b0;
        else if (r_state == S_IDLE && i_valid && o_ready) r_is_req <= 1'b1;
        else if (r_state == S_OUT) r_is_req <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && r_is_req) begin
            o_ok <= r_ok;
            o_found_row <= r_frow;
            o_found_col <= r_fcol;
        end
    end

    logic unused;
    assign unused = ^{pwdata[31:5], paddr[1:0]};
endmodule

>>> hw/rtl/grff_checker.sv
// Checker: port-level assertions for the grid rectangle first-fit unit.
module grff_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_ok,
    input logic [3:0] o_found_row,
    input logic [3:0] o_found_col,
    input logic [8:0] o_free_cells
);
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("request taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_free_cells) && $stable(o_ok))
        else $error("result changed under stall");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_cells <= 9'd256) else $error("free count out of range");
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_found_row == 4'd0 && o_found_col == 4'd0)
        else $error("position set on failure");
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("back-to-back accept");
endmodule

bind grid_rectangle_first_fit_unit grff_checker u_grff_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_ok(o_ok), .o_found_row(o_found_row),
    .o_found_col(o_found_col), .o_free_cells(o_free_cells)
);
